// File: rtl/rcpc_pkg.sv
// ----------------------------------------------------------------------------
// rcpc_pkg
// Types and constants shared by the press classifier modules.
// ----------------------------------------------------------------------------
package rcpc_pkg;

   localparam int unsigned CODE_W = 32;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned PER_W = 16;
   localparam int unsigned CFG_W = 16;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [2:0] EV_STATUS = 3'd0;
   localparam logic [2:0] EV_TALLY = 3'd1;
   localparam logic [2:0] EV_RELEASE = 3'd2;
   localparam logic [2:0] EV_SOLID = 3'd3;
   localparam logic [2:0] EV_MEDIUM = 3'd4;
   localparam logic [2:0] EV_LONG = 3'd5;
   localparam logic [2:0] EV_VLONG = 3'd6;
   localparam logic [2:0] EV_DONE = 3'd7;

   localparam logic [3:0] FL_SOLID = 4'd1;
   localparam logic [3:0] FL_MEDIUM = 4'd2;
   localparam logic [3:0] FL_LONG = 4'd4;
   localparam logic [3:0] FL_VLONG = 4'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_MEDIUM = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VLONG = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE = 2'd3;

   localparam logic [TIME_W-1:0] QUICK_WINDOW_MS = 32'd1000;
   localparam logic [TIME_W-1:0] SERVICE_MS = 32'd20;
   localparam logic [PER_W-1:0] GAP_DEFAULT_MS = 16'd200;
   localparam logic [PER_W-1:0] GAP_MIN_MS = 16'd120;
   localparam logic [PER_W-1:0] GAP_MAX_MS = 16'd600;
   localparam logic [7:0] COUNT_MAX = 8'd255;

   typedef struct packed {
      logic              op;
      logic [31:0]       code;
      logic [15:0]       repeat_period_ms;
      logic [31:0]       now_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [31:0] event_code;
      logic [7:0]  click_count;
      logic [3:0]  press_flags;
      logic [3:0]  tracker_index;
      logic        accepted;
      logic [9:0]  repeat_interval_ms;
      logic [15:0] repeat_count;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] med_ms;
      logic [15:0] long_ms;
      logic [15:0] vlong;
      logic [15:0] idle;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FEED,
      ST_HOLD,
      ST_TAIL,
      ST_SERVICE,
      ST_STATUS
   } eng_state_type;

endpackage

// File: rtl/rcpc_if.sv
// ----------------------------------------------------------------------------
// rcpc_req_if / rcpc_rsp_if
// Valid/ready channels that carry request and result items.
// ----------------------------------------------------------------------------
interface rcpc_req_if;
   logic              valid;
   logic              ready;
   rcpc_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rcpc_rsp_if;
   logic              valid;
   logic              ready;
   rcpc_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/rcpc_front.sv
// ----------------------------------------------------------------------------
// rcpc_front
// Accepts items into a two-entry queue for the tracker engine.
// ----------------------------------------------------------------------------
module rcpc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rcpc_pkg::req_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output rcpc_pkg::req_type out_data
);

   rcpc_pkg::req_type q_ff [2];
   logic              wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data = q_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= in_data;
      end
   end

endmodule

// File: rtl/rcpc_engine.sv
// ----------------------------------------------------------------------------
// rcpc_engine
// Tracker table and sequencer that turns one item into result items.
// ----------------------------------------------------------------------------
module rcpc_engine #(
   parameter int unsigned TRACKER_CNT = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  rcpc_pkg::cfg_type cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  rcpc_pkg::req_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output rcpc_pkg::rsp_type out_data
);

   localparam int unsigned TW = (TRACKER_CNT > 1) ? $clog2(TRACKER_CNT) : 1;

   logic [31:0] code_ff [TRACKER_CNT];
   logic [7:0]  sight_ff [TRACKER_CNT];
   logic [7:0]  tally_ff [TRACKER_CNT];
   logic [3:0]  flags_ff [TRACKER_CNT];
   logic [2:0]  marks_ff [TRACKER_CNT];
   logic        cont_ff [TRACKER_CNT];
   logic        gap_ff [TRACKER_CNT];
   logic [31:0] seen_ff [TRACKER_CNT];
   logic [31:0] hstart_ff [TRACKER_CNT];
   logic [15:0] period_ff [TRACKER_CNT];

   logic [31:0] prev_code_ff, prev_time_ff, svc_time_ff;
   logic [9:0]  interval_ff;
   logic [15:0] quick_ff;

   rcpc_pkg::eng_state_type state_ff, state_in;
   rcpc_pkg::req_type       item_ff;
   logic [TW-1:0]           t_ff;
   logic [1:0]              sub_ff;
   logic                    taken_ff;

   rcpc_pkg::rsp_type ob_ff;
   logic              ob_valid_ff;
   logic              ob_free;
   assign ob_free = !ob_valid_ff || out_ready;
   assign out_valid = ob_valid_ff;
   assign out_data = ob_ff;

   // Lookup of the taking tracker: match first, else first empty.
   logic          hit, empty_found;
   logic [TW-1:0] hit_idx, empty_idx;
   always_comb begin
      hit = 1'b0;
      empty_found = 1'b0;
      hit_idx = '0;
      empty_idx = '0;
      for (int i = TRACKER_CNT - 1; i >= 0; i--) begin
         if (code_ff[i] == in_data.code) begin
            hit = 1'b1;
            hit_idx = TW'(i);
         end
         if (code_ff[i] == 32'd0) begin
            empty_found = 1'b1;
            empty_idx = TW'(i);
         end
      end
   end

   assign in_ready = (state_ff == rcpc_pkg::ST_IDLE);
   logic accept;
   assign accept = in_valid && in_ready;
   logic take;
   assign take = !in_data.op && in_data.code != 32'd0 && (hit || empty_found);

   // Per tracker working values.
   logic [31:0] cur_code, cur_seen, cur_hstart, elapsed, hd;
   logic [7:0]  cur_sight, cur_tally;
   logic [3:0]  cur_flags;
   logic [2:0]  cur_marks;
   logic [15:0] cur_per, gap, half, lim;
   logic        held, need_rel, need_done;
   logic [2:0]  hmark;
   logic [3:0]  hflag;
   logic [2:0]  hev;
   always_comb begin
      cur_code = code_ff[t_ff];
      cur_seen = seen_ff[t_ff];
      cur_hstart = hstart_ff[t_ff];
      cur_sight = sight_ff[t_ff];
      cur_tally = tally_ff[t_ff];
      cur_flags = flags_ff[t_ff];
      cur_marks = marks_ff[t_ff];
      cur_per = period_ff[t_ff];
      half = {1'b0, cur_per[15:1]};
      if (cur_per == 16'd0) begin
         gap = rcpc_pkg::GAP_DEFAULT_MS;
      end else if (half < rcpc_pkg::GAP_MIN_MS) begin
         gap = rcpc_pkg::GAP_MIN_MS;
      end else if (half > rcpc_pkg::GAP_MAX_MS) begin
         gap = rcpc_pkg::GAP_MAX_MS;
      end else begin
         gap = half;
      end
      elapsed = item_ff.now_ms - cur_seen;
      need_rel = (elapsed >= {16'd0, gap});
      need_done = (elapsed > {16'd0, cfg.idle});
      case (sub_ff)
         2'd0: begin
            lim = cfg.med_ms;
            hmark = 3'b001;
            hflag = rcpc_pkg::FL_MEDIUM;
            hev = rcpc_pkg::EV_MEDIUM;
         end
         2'd1: begin
            lim = cfg.long_ms;
            hmark = 3'b010;
            hflag = rcpc_pkg::FL_LONG;
            hev = rcpc_pkg::EV_LONG;
         end
         default: begin
            lim = cfg.vlong;
            hmark = 3'b100;
            hflag = rcpc_pkg::FL_VLONG;
            hev = rcpc_pkg::EV_VLONG;
         end
      endcase
      hd = item_ff.now_ms - cur_hstart;
      held = !hd[31] && (hd >= {16'd0, lim}) && !(|(cur_marks & hmark));
   end

   logic last_t;
   assign last_t = (t_ff == TW'(TRACKER_CNT - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rcpc_pkg::ST_IDLE: begin
            if (accept) begin
               if (in_data.op) begin
                  state_in = (in_data.now_ms - svc_time_ff >= rcpc_pkg::SERVICE_MS) ?
                     rcpc_pkg::ST_SERVICE : rcpc_pkg::ST_STATUS;
               end else if (take) begin
                  state_in = rcpc_pkg::ST_FEED;
               end else begin
                  state_in = rcpc_pkg::ST_STATUS;
               end
            end
         end
         rcpc_pkg::ST_FEED: begin
            if (ob_free) begin
               state_in = (cur_code != item_ff.code) ? rcpc_pkg::ST_STATUS
                                                    : rcpc_pkg::ST_HOLD;
            end
         end
         rcpc_pkg::ST_HOLD: begin
            if (ob_free && sub_ff == 2'd2) begin
               state_in = rcpc_pkg::ST_TAIL;
            end
         end
         rcpc_pkg::ST_TAIL: begin
            if (ob_free && sub_ff == 2'd1) begin
               state_in = rcpc_pkg::ST_STATUS;
            end
         end
         rcpc_pkg::ST_SERVICE: begin
            if (ob_free && (cur_code == 32'd0 || sub_ff == 2'd1) && last_t) begin
               state_in = rcpc_pkg::ST_STATUS;
            end
         end
         rcpc_pkg::ST_STATUS: begin
            if (ob_free) begin
               state_in = rcpc_pkg::ST_IDLE;
            end
         end
         default: state_in = rcpc_pkg::ST_IDLE;
      endcase
   end

   // Result produced in the current state, if any.
   logic              emit;
   rcpc_pkg::rsp_type ev;
   logic [7:0]        sight_inc;
   logic [7:0]        tally_inc;
   always_comb begin
      emit = 1'b0;
      ev = '0;
      ev.event_code = cur_code;
      ev.tracker_index = 4'(t_ff);
      sight_inc = (cur_sight < rcpc_pkg::COUNT_MAX) ? cur_sight + 8'd1 : cur_sight;
      tally_inc = (cur_tally < rcpc_pkg::COUNT_MAX) ? cur_tally + 8'd1 : cur_tally;
      case (state_ff)
         rcpc_pkg::ST_FEED: begin
            if (cur_code != item_ff.code) begin
               emit = 1'b1;
               ev.event_res = rcpc_pkg::EV_TALLY;
               ev.event_code = item_ff.code;
               ev.click_count = 8'd1;
            end
         end
         rcpc_pkg::ST_HOLD: begin
            if (held) begin
               emit = 1'b1;
               ev.event_res = hev;
               ev.press_flags = cur_flags | hflag;
            end
         end
         rcpc_pkg::ST_TAIL: begin
            if (sub_ff == 2'd0 && cur_sight == 8'd2) begin
               emit = 1'b1;
               ev.event_res = rcpc_pkg::EV_SOLID;
               ev.press_flags = cur_flags | rcpc_pkg::FL_SOLID;
            end else if (sub_ff == 2'd1 && gap_ff[t_ff]) begin
               emit = 1'b1;
               ev.event_res = rcpc_pkg::EV_TALLY;
               ev.click_count = tally_inc;
               ev.press_flags = cur_flags;
            end
         end
         rcpc_pkg::ST_SERVICE: begin
            if (cur_code != 32'd0) begin
               if (sub_ff == 2'd0 && need_rel && !gap_ff[t_ff]) begin
                  emit = 1'b1;
                  ev.event_res = rcpc_pkg::EV_RELEASE;
                  ev.click_count = cur_tally;
                  ev.press_flags = cur_flags;
               end else if (sub_ff == 2'd1 && need_done) begin
                  emit = 1'b1;
                  ev.event_res = rcpc_pkg::EV_DONE;
                  ev.click_count = cur_tally;
                  ev.press_flags = cur_flags;
               end
            end
         end
         rcpc_pkg::ST_STATUS: begin
            emit = 1'b1;
            ev.event_res = rcpc_pkg::EV_STATUS;
            ev.event_code = item_ff.op ? 32'd0 : item_ff.code;
            ev.tracker_index = taken_ff ? 4'(t_ff) : 4'd0;
            ev.accepted = taken_ff;
            ev.repeat_interval_ms = interval_ff;
            ev.repeat_count = quick_ff;
            ev.last = 1'b1;
         end
         default: emit = 1'b0;
      endcase
   end

   logic [31:0] qd;
   assign qd = in_data.now_ms - prev_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rcpc_pkg::ST_IDLE;
         ob_valid_ff <= 1'b0;
         prev_code_ff <= '0;
         prev_time_ff <= '0;
         svc_time_ff <= '0;
         interval_ff <= '0;
         quick_ff <= '0;
         t_ff <= '0;
         sub_ff <= '0;
         taken_ff <= 1'b0;
         for (int i = 0; i < TRACKER_CNT; i++) begin
            code_ff[i] <= '0;
            sight_ff[i] <= '0;
            tally_ff[i] <= '0;
            flags_ff[i] <= '0;
            marks_ff[i] <= '0;
            cont_ff[i] <= 1'b0;
            gap_ff[i] <= 1'b0;
            seen_ff[i] <= '0;
            hstart_ff[i] <= '0;
            period_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (emit && ob_free) begin
            ob_valid_ff <= 1'b1;
            ob_ff <= ev;
         end else if (out_ready) begin
            ob_valid_ff <= 1'b0;
         end
         case (state_ff)
            rcpc_pkg::ST_IDLE: begin
               sub_ff <= '0;
               if (accept) begin
                  item_ff <= in_data;
                  t_ff <= take ? (hit ? hit_idx : empty_idx) : '0;
                  taken_ff <= take;
                  if (in_data.op) begin
                     if (in_data.now_ms - svc_time_ff >= rcpc_pkg::SERVICE_MS) begin
                        svc_time_ff <= in_data.now_ms;
                     end
                  end else begin
                     if (in_data.code == prev_code_ff) begin
                        if (qd > rcpc_pkg::QUICK_WINDOW_MS) begin
                           interval_ff <= '0;
                           quick_ff <= '0;
                        end else begin
                           interval_ff <= qd[9:0];
                           if (quick_ff != 16'hFFFF) begin
                              quick_ff <= quick_ff + 16'd1;
                           end
                        end
                     end else begin
                        quick_ff <= '0;
                        prev_code_ff <= in_data.code;
                        interval_ff <= '0;
                     end
                     prev_time_ff <= in_data.now_ms;
                  end
               end
            end
            rcpc_pkg::ST_FEED: begin
               if (ob_free) begin
                  period_ff[t_ff] <= item_ff.repeat_period_ms;
                  seen_ff[t_ff] <= item_ff.now_ms;
                  if (cur_code != item_ff.code) begin
                     code_ff[t_ff] <= item_ff.code;
                     sight_ff[t_ff] <= 8'd1;
                     flags_ff[t_ff] <= '0;
                     tally_ff[t_ff] <= 8'd1;
                     marks_ff[t_ff] <= '0;
                     hstart_ff[t_ff] <= item_ff.now_ms;
                     cont_ff[t_ff] <= 1'b1;
                  end else if (!cont_ff[t_ff]) begin
                     hstart_ff[t_ff] <= item_ff.now_ms;
                  end
               end
            end
            rcpc_pkg::ST_HOLD: begin
               if (ob_free) begin
                  if (held) begin
                     marks_ff[t_ff] <= cur_marks | hmark;
                     flags_ff[t_ff] <= cur_flags | hflag;
                  end
                  sub_ff <= (sub_ff == 2'd2) ? 2'd0 : sub_ff + 2'd1;
                  if (sub_ff == 2'd2) begin
                     sight_ff[t_ff] <= sight_inc;
                  end
               end
            end
            rcpc_pkg::ST_TAIL: begin
               if (ob_free) begin
                  if (sub_ff == 2'd0) begin
                     if (cur_sight == 8'd2) begin
                        flags_ff[t_ff] <= cur_flags | rcpc_pkg::FL_SOLID;
                     end
                     sub_ff <= 2'd1;
                  end else begin
                     if (gap_ff[t_ff]) begin
                        gap_ff[t_ff] <= 1'b0;
                        tally_ff[t_ff] <= tally_inc;
                     end
                     cont_ff[t_ff] <= 1'b1;
                     sub_ff <= 2'd0;
                  end
               end
            end
            rcpc_pkg::ST_SERVICE: begin
               if (ob_free) begin
                  if (cur_code == 32'd0 || sub_ff == 2'd1) begin
                     sub_ff <= '0;
                     if (!last_t) begin
                        t_ff <= t_ff + TW'(1);
                     end
                     if (cur_code != 32'd0 && need_done) begin
                        code_ff[t_ff] <= '0;
                        sight_ff[t_ff] <= '0;
                        gap_ff[t_ff] <= 1'b0;
                        flags_ff[t_ff] <= '0;
                        cont_ff[t_ff] <= 1'b0;
                     end
                  end else begin
                     sub_ff <= 2'd1;
                     if (need_rel) begin
                        if (cur_sight == 8'd1) begin
                           sight_ff[t_ff] <= '0;
                        end
                        gap_ff[t_ff] <= 1'b1;
                        cont_ff[t_ff] <= 1'b0;
                        marks_ff[t_ff] <= '0;
                     end
                  end
               end
            end
            default: sub_ff <= sub_ff;
         endcase
      end
   end

endmodule

// File: rtl/repeat_code_press_classifier.sv
// ----------------------------------------------------------------------------
// repeat_code_press_classifier
// Classifies repeated button codes into click, release, hold, solid and done events.
// ----------------------------------------------------------------------------
// The engine takes a new item only once the status item of the last one is
// registered for output; a code steps through feed, hold and tail checks, a
// service tick through release and done checks per tracker, and an output
// stall holds the sequencer. A two-entry input queue accepts items while the
// engine is busy, until it is full.
// Synchronous reset empties all trackers and loads the default thresholds.
module repeat_code_press_classifier #(
   parameter int unsigned TRACKER_CNT = 4
) (
   input  logic        clock,
   input  logic        reset,
   rcpc_req_if.sink    req,
   rcpc_rsp_if.source  rsp,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   rcpc_pkg::cfg_type cfg_ff;
   logic              q_valid, q_ready;
   rcpc_pkg::req_type q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.med_ms <= 16'd600;
         cfg_ff.long_ms <= 16'd1500;
         cfg_ff.vlong <= 16'd4000;
         cfg_ff.idle <= 16'd2000;
      end else if (csr_write_enable) begin
         case (csr_index)
            rcpc_pkg::CSR_MEDIUM: cfg_ff.med_ms <= csr_write_data;
            rcpc_pkg::CSR_LONG: cfg_ff.long_ms <= csr_write_data;
            rcpc_pkg::CSR_VLONG: cfg_ff.vlong <= csr_write_data;
            rcpc_pkg::CSR_IDLE: cfg_ff.idle <= csr_write_data;
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   rcpc_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.payload),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   rcpc_engine #(.TRACKER_CNT(TRACKER_CNT)) u_engine (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.payload)
   );

endmodule

// File: rtl/rcpc_checker.sv
// ----------------------------------------------------------------------------
// rcpc_checker
// Port level checks on the result channel of the press classifier.
// ----------------------------------------------------------------------------
module rcpc_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input rcpc_pkg::rsp_type rsp_payload
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_last_is_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last |-> rsp_payload.event_res == rcpc_pkg::EV_STATUS)
      else $error("last item is not a status item");

   a_event_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last |->
         !rsp_payload.accepted && rsp_payload.repeat_count == 16'd0)
      else $error("event item carries status fields");

   a_solid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.event_res == rcpc_pkg::EV_SOLID |->
         rsp_payload.click_count == 8'd0 && rsp_payload.press_flags[0])
      else $error("bad solid item");

endmodule

bind repeat_code_press_classifier rcpc_checker u_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);

// File: sim/tb_repeat_code_press_classifier.sv
// ----------------------------------------------------------------------------
// tb_repeat_code_press_classifier
// Drives code and service items into the press classifier, predicts every
// click, release, hold, solid, done and status item, and checks the results in order.
// ----------------------------------------------------------------------------
module tb_repeat_code_press_classifier;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NTRK = 4;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [1:0] csr_index;
   logic [15:0] csr_write_data;

   rcpc_req_if req_ch ();
   rcpc_rsp_if rsp_ch ();

   repeat_code_press_classifier #(.TRACKER_CNT(NTRK)) u_dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Predictor state.
   logic [15:0] thr_medium, thr_long, thr_vlong, thr_idle;
   logic [31:0] trk_code [NTRK];
   logic [7:0]  trk_sight [NTRK];
   logic [7:0]  trk_tally [NTRK];
   logic [3:0]  trk_flags [NTRK];
   logic [2:0]  trk_marks [NTRK];
   logic        trk_cont [NTRK];
   logic        trk_gap [NTRK];
   logic [31:0] trk_seen [NTRK];
   logic [31:0] trk_hold [NTRK];
   logic [15:0] trk_period [NTRK];
   logic [31:0] prev_code, prev_feed, last_service;
   logic [15:0] interval_ms, quick_count;

   rcpc_pkg::req_type pending_items [$];
   rcpc_pkg::rsp_type expected_events [$];
   int errors;
   bit no_idle;
   int watchdog;

   task automatic report(input string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic rcpc_pkg::rsp_type make_event(input logic [2:0] ev,
                                                    input logic [31:0] c,
                                                    input logic [7:0] cnt,
                                                    input logic [3:0] fl,
                                                    input int t);
      rcpc_pkg::rsp_type r;
      r = '0;
      r.event_res = ev;
      r.event_code = c;
      r.click_count = cnt;
      r.press_flags = fl;
      r.tracker_index = 4'(t);
      return r;
   endfunction

   function automatic void hold_test(input int t, input logic [31:0] now,
                                     input logic [2:0] mark, input logic [3:0] fl,
                                     input logic [15:0] lim, input logic [2:0] ev);
      logic [31:0] d;
      d = now - trk_hold[t];
      if ((trk_marks[t] & mark) == 0 && !d[31] && d >= {16'd0, lim}) begin
         trk_marks[t] |= mark;
         trk_flags[t] |= fl;
         expected_events.push_back(make_event(ev, trk_code[t], 8'd0, trk_flags[t], t));
      end
   endfunction

   function automatic void predict_feed(input int t, input logic [31:0] c,
                                        input logic [15:0] per, input logic [31:0] now);
      trk_period[t] = per;
      trk_seen[t] = now;
      if (trk_code[t] != c) begin
         trk_code[t] = c;
         trk_sight[t] = 8'd1;
         trk_flags[t] = '0;
         trk_tally[t] = 8'd1;
         trk_marks[t] = '0;
         trk_hold[t] = now;
         expected_events.push_back(make_event(rcpc_pkg::EV_TALLY, c, 8'd1, 4'd0, t));
      end else begin
         if (!trk_cont[t]) trk_hold[t] = now;
         hold_test(t, now, 3'd1, rcpc_pkg::FL_MEDIUM, thr_medium, rcpc_pkg::EV_MEDIUM);
         hold_test(t, now, 3'd2, rcpc_pkg::FL_LONG, thr_long, rcpc_pkg::EV_LONG);
         hold_test(t, now, 3'd4, rcpc_pkg::FL_VLONG, thr_vlong, rcpc_pkg::EV_VLONG);
         if (trk_sight[t] < rcpc_pkg::COUNT_MAX) trk_sight[t]++;
         if (trk_sight[t] == 8'd2) begin
            trk_flags[t] |= rcpc_pkg::FL_SOLID;
            expected_events.push_back(make_event(rcpc_pkg::EV_SOLID, c, 8'd0,
                                                 trk_flags[t], t));
         end
         if (trk_gap[t]) begin
            trk_gap[t] = 1'b0;
            if (trk_tally[t] < rcpc_pkg::COUNT_MAX) trk_tally[t]++;
            expected_events.push_back(make_event(rcpc_pkg::EV_TALLY, c, trk_tally[t],
                                                 trk_flags[t], t));
         end
      end
      trk_cont[t] = 1'b1;
   endfunction

   function automatic void predict_service(input int t, input logic [31:0] now);
      logic [31:0] gap, elapsed;
      if (trk_code[t] == 0) return;
      gap = 32'(rcpc_pkg::GAP_DEFAULT_MS);
      if (trk_period[t] != 0) begin
         gap = 32'(trk_period[t] >> 1);
         if (gap < 32'(rcpc_pkg::GAP_MIN_MS)) gap = 32'(rcpc_pkg::GAP_MIN_MS);
         else if (gap > 32'(rcpc_pkg::GAP_MAX_MS)) gap = 32'(rcpc_pkg::GAP_MAX_MS);
      end
      elapsed = now - trk_seen[t];
      if (elapsed >= gap) begin
         if (trk_sight[t] == 8'd1) trk_sight[t] = 8'd0;
         if (!trk_gap[t]) begin
            trk_gap[t] = 1'b1;
            expected_events.push_back(make_event(rcpc_pkg::EV_RELEASE, trk_code[t],
                                                 trk_tally[t], trk_flags[t], t));
         end
         trk_cont[t] = 1'b0;
         trk_marks[t] = '0;
      end
      if (elapsed > {16'd0, thr_idle}) begin
         expected_events.push_back(make_event(rcpc_pkg::EV_DONE, trk_code[t],
                                              trk_tally[t], trk_flags[t], t));
         trk_code[t] = '0;
         trk_sight[t] = '0;
         trk_gap[t] = 1'b0;
         trk_flags[t] = '0;
         trk_cont[t] = 1'b0;
      end
   endfunction

   function automatic void predict_item(input rcpc_pkg::req_type it);
      int taker;
      logic [31:0] d;
      rcpc_pkg::rsp_type st;
      taker = -1;
      if (it.op == 1'b0) begin
         if (it.code == prev_code) begin
            d = it.now_ms - prev_feed;
            if (d > rcpc_pkg::QUICK_WINDOW_MS) begin
               interval_ms = '0;
               quick_count = '0;
            end else begin
               interval_ms = d[15:0];
               if (quick_count != 16'hFFFF) quick_count++;
            end
         end else begin
            quick_count = '0;
            prev_code = it.code;
            interval_ms = '0;
         end
         prev_feed = it.now_ms;
         if (it.code != 0) begin
            for (int t = 0; t < NTRK && taker < 0; t++)
               if (trk_code[t] == it.code) taker = t;
            for (int t = 0; t < NTRK && taker < 0; t++)
               if (trk_code[t] == 0) taker = t;
            if (taker >= 0) predict_feed(taker, it.code, it.repeat_period_ms, it.now_ms);
         end
      end else if (it.now_ms - last_service >= rcpc_pkg::SERVICE_MS) begin
         last_service = it.now_ms;
         for (int t = 0; t < NTRK; t++) predict_service(t, it.now_ms);
      end
      st = make_event(rcpc_pkg::EV_STATUS, it.op ? 32'd0 : it.code, 8'd0, 4'd0,
                      taker >= 0 ? taker : 0);
      st.accepted = taker >= 0;
      st.repeat_interval_ms = interval_ms[9:0];
      st.repeat_count = quick_count;
      st.last = 1'b1;
      expected_events.push_back(st);
   endfunction

   // Driver.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) predict_item(req_ch.payload);
         if (pending_items.size() > 0 && (no_idle || $urandom_range(99) >= 7)) begin
            req_ch.payload <= pending_items.pop_front();
            req_ch.valid <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      rcpc_pkg::rsp_type exp_r, got;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (expected_events.size() == 0) begin
               report($sformatf("unexpected result %p", got));
            end else begin
               exp_r = expected_events.pop_front();
               if (got.event_res !== exp_r.event_res)
                  report($sformatf("event_res %0d exp %0d", got.event_res, exp_r.event_res));
               if (got.event_code !== exp_r.event_code)
                  report($sformatf("event_code %h exp %h", got.event_code, exp_r.event_code));
               if (got.click_count !== exp_r.click_count)
                  report($sformatf("click_count %0d exp %0d", got.click_count,
                                   exp_r.click_count));
               if (got.press_flags !== exp_r.press_flags)
                  report($sformatf("press_flags %h exp %h", got.press_flags,
                                   exp_r.press_flags));
               if (got.tracker_index !== exp_r.tracker_index)
                  report($sformatf("tracker_index %0d exp %0d", got.tracker_index,
                                   exp_r.tracker_index));
               if (got.accepted !== exp_r.accepted)
                  report($sformatf("accepted %b exp %b", got.accepted, exp_r.accepted));
               if (got.repeat_interval_ms !== exp_r.repeat_interval_ms)
                  report($sformatf("repeat_interval_ms %0d exp %0d",
                                   got.repeat_interval_ms, exp_r.repeat_interval_ms));
               if (got.repeat_count !== exp_r.repeat_count)
                  report($sformatf("repeat_count %0d exp %0d", got.repeat_count,
                                   exp_r.repeat_count));
               if (got.last !== exp_r.last)
                  report($sformatf("last %b exp %b", got.last, exp_r.last));
            end
         end
         rsp_ch.ready <= no_idle || $urandom_range(99) >= 7;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         watchdog <= 0;
      else
         watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
         $display("FAIL repeat_code_press_classifier");
         $finish;
      end
   end

   logic [31:0] sim_ms;
   logic [31:0] code_pool [6];

   task automatic add_item(input logic op, input logic [31:0] c, input logic [15:0] per,
                           input logic [31:0] now);
      rcpc_pkg::req_type it;
      it.op = op;
      it.code = c;
      it.repeat_period_ms = per;
      it.now_ms = now;
      pending_items.push_back(it);
   endtask

   task automatic drain();
      while (pending_items.size() > 0 || req_ch.valid || expected_events.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         rcpc_pkg::CSR_MEDIUM: thr_medium = val;
         rcpc_pkg::CSR_LONG: thr_long = val;
         rcpc_pkg::CSR_VLONG: thr_vlong = val;
         default: thr_idle = val;
      endcase
   endtask

   // A burst of repeats of one code, with service ticks mixed in at random.
   task automatic press_burst(input logic [31:0] c, input int reps, input logic [15:0] per,
                              input int step);
      for (int k = 0; k < reps; k++) begin
         add_item(1'b0, c, per, sim_ms);
         sim_ms += step;
         if ($urandom_range(3) == 0) add_item(1'b1, 32'd0, 16'd0, sim_ms);
      end
   endtask

   initial begin
      errors = 0;
      no_idle = 0;
      watchdog = 0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = rcpc_pkg::CSR_MEDIUM;
      csr_write_data = '0;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      thr_medium = 16'd600;
      thr_long = 16'd1500;
      thr_vlong = 16'd4000;
      thr_idle = 16'd2000;
      for (int t = 0; t < NTRK; t++) begin
         trk_code[t] = '0; trk_sight[t] = '0; trk_tally[t] = '0; trk_flags[t] = '0;
         trk_marks[t] = '0; trk_cont[t] = 0; trk_gap[t] = 0; trk_seen[t] = '0;
         trk_hold[t] = '0; trk_period[t] = '0;
      end
      prev_code = '0; prev_feed = '0; last_service = '0;
      interval_ms = '0; quick_count = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, code zero, no free tracker, throttle, holds, done.
      sim_ms = 32'd100;
      add_item(1'b0, 32'd0, 16'd0, sim_ms);
      add_item(1'b0, 32'hFFFF_FFFF, 16'hFFFF, sim_ms + 10);
      add_item(1'b0, 32'hFFFF_FFFF, 16'hFFFF, sim_ms + 110);
      add_item(1'b0, 32'h1, 16'd1, sim_ms + 120);
      add_item(1'b0, 32'h2, 16'd240, sim_ms + 130);
      add_item(1'b0, 32'h3, 16'd0, sim_ms + 140);
      add_item(1'b0, 32'h4, 16'd0, sim_ms + 150);
      add_item(1'b1, 32'hFFFF_FFFF, 16'hFFFF, sim_ms + 400);
      add_item(1'b1, 32'd0, 16'd0, sim_ms + 410);
      add_item(1'b0, 32'h1, 16'd1, sim_ms + 500);
      add_item(1'b0, 32'h1, 16'd1, sim_ms + 5000);
      add_item(1'b0, 32'h1, 16'd1, sim_ms + 5001);
      add_item(1'b1, 32'd0, 16'd0, sim_ms + 9000);
      add_item(1'b0, 32'h5, 16'd0, 32'hFFFF_FFF0);
      add_item(1'b0, 32'h5, 16'd0, 32'h0000_0010);
      add_item(1'b0, 32'h5, 16'd0, 32'h0000_0005);
      add_item(1'b1, 32'd0, 16'd0, 32'h0001_0000);
      drain();

      write_reg(rcpc_pkg::CSR_MEDIUM, 16'd0);
      write_reg(rcpc_pkg::CSR_LONG, 16'd0);
      write_reg(rcpc_pkg::CSR_VLONG, 16'hFFFF);
      write_reg(rcpc_pkg::CSR_IDLE, 16'd0);
      sim_ms = 32'h0002_0000;
      add_item(1'b0, 32'h77, 16'd80, sim_ms);
      add_item(1'b0, 32'h77, 16'd80, sim_ms + 50);
      add_item(1'b1, 32'd0, 16'd0, sim_ms + 100);
      add_item(1'b1, 32'd0, 16'd0, sim_ms + 500);
      drain();

      // Random bursts of repeated codes with ticks; several threshold settings.
      for (int phase = 0; phase < 4; phase++) begin
         write_reg(rcpc_pkg::CSR_MEDIUM,
                   phase == 3 ? 16'hFFFF : 16'($urandom_range(100, 800)));
         write_reg(rcpc_pkg::CSR_LONG, 16'($urandom_range(200, 1800)));
         write_reg(rcpc_pkg::CSR_VLONG, 16'($urandom_range(300, 3000)));
         write_reg(rcpc_pkg::CSR_IDLE,
                   phase == 3 ? 16'hFFFF : 16'($urandom_range(300, 2500)));
         for (int k = 0; k < 6; k++) code_pool[k] = $urandom();
         code_pool[5] = 32'h8000_0000 | 32'($urandom_range(15));
         no_idle = phase == 2;
         sim_ms = $urandom();
         for (int b = 0; b < 6; b++) begin
            if ($urandom_range(7) == 0)
               add_item(1'($urandom_range(1)), $urandom(), 16'($urandom()), $urandom());
            press_burst(code_pool[$urandom_range(5)], $urandom_range(1, 8),
                        16'($urandom_range(0, 1300)), $urandom_range(40, 260));
            sim_ms += $urandom_range(100, 3000);
            add_item(1'b1, 32'd0, 16'd0, sim_ms);
            sim_ms += $urandom_range(0, 30);
         end
         drain();
      end

      if (errors == 0) begin
         $display("PASS repeat_code_press_classifier");
      end else begin
         $display("FAIL repeat_code_press_classifier");
      end
      $finish;
   end

endmodule
